@@ sv/b62stc_pkg.sv @@
package b62stc_pkg;

    localparam int ACC_W      = 56;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int SCALE_W    = 15;     // width of byte * 67

    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_VALUE   = 2'd1;

    localparam logic [6:0] RADIX      = 7'd62;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } b62stc_digit_t;

    typedef struct packed {
        logic take;         // input word accepted this cycle
        logic mul;          // load product into the shift register
        logic div_start;    // clear remainder before a radix division
        logic enc_step;     // eight bits of division by 62
        logic digit_store;  // write the finished digit, advance the count
        logic dec_step;     // one bit of division by key*67
        logic emit_digit;
        logic emit_space;
        logic emit_dec;
    } b62stc_cmd_t;

    typedef struct packed {
        logic decode_mode;
        logic in_is_space;
        logic prod_zero;
        logic n_full;
        logic n_zero;
        logic out_free;
    } b62stc_sts_t;

    // shift register width: product rounded up to whole bytes, at least the accumulator
    function automatic int sh_width(input int key_bits);
        int qw;
        qw = ((key_bits + SCALE_W + 7) >> 3) << 3;
        return (qw > ACC_W) ? qw : ACC_W;
    endfunction

    function automatic b62stc_digit_t digit_of(input logic [7:0] c);
        b62stc_digit_t d;
        d.valid = 1'b1;
        d.value = 6'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = 6'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            d.value = 6'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            d.value = 6'(c - 8'h41 + 8'd36);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    function automatic logic [7:0] char_of(input logic [5:0] d);
        logic [7:0] c;
        if (d < 6'd10) begin
            c = 8'h30 + 8'(d);
        end else if (d < 6'd36) begin
            c = 8'h61 + 8'(d - 6'd10);
        end else if (d < 6'd62) begin
            c = 8'h41 + 8'(d - 6'd36);
        end else begin
            c = 8'h30;
        end
        return c;
    endfunction

endpackage

@@ sv/b62stc_ctrl.sv @@
module b62stc_ctrl
    import b62stc_pkg::*;
#(
    parameter int KEY_BITS = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  b62stc_sts_t sts,
    output b62stc_cmd_t cmd
);

    localparam int SH_W  = sh_width(KEY_BITS);
    localparam int CNT_W = $clog2(SH_W);
    localparam logic [CNT_W-1:0] ENC_LAST = CNT_W'(SH_W / 8 - 1);
    localparam logic [CNT_W-1:0] DEC_LAST = CNT_W'(SH_W - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_ECHK  = 7'b0000100,
        S_EDIV  = 7'b0001000,
        S_EEMIT = 7'b0010000,
        S_DDIV  = 7'b0100000,
        S_DEMIT = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    cnt_next = '0;
                    if (!sts.decode_mode)
                    begin
                        state_next = S_MUL;
                    end
                    else if (sts.in_is_space)
                    begin
                        state_next = S_DDIV;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ECHK;
            end
            S_ECHK:
            begin
                if (sts.prod_zero || sts.n_full)
                begin
                    state_next = S_EEMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_EDIV;
                end
            end
            S_EDIV:
            begin
                cmd.enc_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ENC_LAST)
                begin
                    cmd.digit_store = 1'b1;
                    state_next      = S_ECHK;
                end
            end
            S_EEMIT:
            begin
                if (sts.out_free)
                begin
                    if (sts.n_zero)
                    begin
                        cmd.emit_space = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_digit = 1'b1;
                    end
                end
            end
            S_DDIV:
            begin
                cmd.dec_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DEC_LAST)
                begin
                    state_next = S_DEMIT;
                end
            end
            S_DEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_dec = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/b62stc_dp.sv @@
module b62stc_dp
    import b62stc_pkg::*;
#(
    parameter int KEY_BITS   = 40,
    parameter int MAX_DIGITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            in_byte,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  last_of_run,
    output logic                  bad_text,
    input  b62stc_cmd_t           cmd,
    output b62stc_sts_t           sts
);

    localparam int SH_W   = sh_width(KEY_BITS);
    localparam int PROD_W = SCALE_W + KEY_BITS;
    localparam int DIV_W  = KEY_BITS + 7;
    localparam int NW     = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = $clog2(MAX_DIGITS);

    logic                  mode_reg, mode_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  ov_reg, ov_next;
    logic [NW-1:0]         n_reg, n_next;
    logic                  out_valid_reg, out_valid_next;

    logic [SCALE_W-1:0]    m_reg, m_next;
    logic [SH_W-1:0]       sh_reg, sh_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      divisor_reg, divisor_next;
    logic                  bad_word_reg, bad_word_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  last_reg, last_next;
    logic                  bad_reg, bad_next;
    logic [5:0]            buf_reg [MAX_DIGITS];

    logic [PROD_W-1:0]     prod;
    logic [ACC_W+6:0]      acc_mac;
    b62stc_digit_t         dig;
    logic                  key_zero;
    logic                  out_free;
    logic [5:0]            enc_rem;
    logic [7:0]            enc_q;
    logic [DIV_W:0]        dec_try;
    logic                  dec_qb;
    logic [DIV_W-1:0]      dec_rem;
    logic [IDX_W-1:0]      rd_idx;

    assign prod     = PROD_W'(m_reg) * PROD_W'(key_reg);
    assign dig      = digit_of(in_byte);
    assign key_zero = (key_reg == '0);
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_idx   = IDX_W'(n_reg - 1'b1);
    // acc*62 + d, checked against the 56-bit range
    assign acc_mac  = ((ACC_W+7)'(acc_reg) << 6) - ((ACC_W+7)'(acc_reg) << 1)
                      + (ACC_W+7)'(dig.value);

    // eight restoring steps of division by 62
    always_comb
    begin
        logic [6:0] r7;
        logic [5:0] r6;
        r6    = rem_reg[5:0];
        enc_q = '0;
        for (int j = 0; j < 8; j++)
        begin
            r7 = {r6, sh_reg[SH_W-1-j]};
            if (r7 >= RADIX)
            begin
                r6         = 6'(r7 - RADIX);
                enc_q[7-j] = 1'b1;
            end
            else
            begin
                r6 = r7[5:0];
            end
        end
        enc_rem = r6;
    end

    always_comb
    begin
        dec_try = {rem_reg, sh_reg[SH_W-1]};
        dec_qb  = (dec_try >= {1'b0, divisor_reg});
        dec_rem = dec_qb ? DIV_W'(dec_try - {1'b0, divisor_reg}) : dec_try[DIV_W-1:0];
    end

    always_comb
    begin
        mode_next      = mode_reg;
        key_next       = key_reg;
        acc_next       = acc_reg;
        ov_next        = ov_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg;
        m_next         = m_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        bad_word_next  = bad_word_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;

        if (cfg_write_en && cfg_index == CFG_DECODE_MODE)
        begin
            mode_next = cfg_data[0];
        end
        if (cfg_write_en && cfg_index == CFG_KEY_VALUE)
        begin
            key_next = KEY_BITS'({{KEY_BITS{1'b0}}, cfg_data});
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.take)
        begin
            if (!mode_reg)
            begin
                m_next = (SCALE_W'(in_byte) << 6) + (SCALE_W'(in_byte) << 1)
                         + SCALE_W'(in_byte);
                n_next = '0;
            end
            else if (in_byte == SPACE_CHAR)
            begin
                sh_next       = SH_W'(acc_reg);
                rem_next      = '0;
                divisor_next  = (DIV_W'(key_reg) << 6) + (DIV_W'(key_reg) << 1)
                                + DIV_W'(key_reg);
                bad_word_next = ov_reg || key_zero;
                acc_next      = '0;
                ov_next       = 1'b0;
            end
            else if (!dig.valid)
            begin
                ov_next = 1'b1;
            end
            else if (!ov_reg)
            begin
                if (acc_mac[ACC_W+6:ACC_W] != '0)
                begin
                    ov_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_mac[ACC_W-1:0];
                end
            end
        end

        if (cmd.mul)
        begin
            sh_next = SH_W'(prod);
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
        end
        if (cmd.enc_step)
        begin
            sh_next  = {sh_reg[SH_W-9:0], enc_q};
            rem_next = DIV_W'(enc_rem);
        end
        if (cmd.digit_store)
        begin
            n_next = n_reg + 1'b1;
        end
        if (cmd.dec_step)
        begin
            sh_next  = {sh_reg[SH_W-2:0], dec_qb};
            rem_next = dec_rem;
        end

        if (cmd.emit_digit)
        begin
            out_byte_next  = char_of(buf_reg[rd_idx]);
            last_next      = 1'b0;
            bad_next       = 1'b0;
            out_valid_next = 1'b1;
            n_next         = n_reg - 1'b1;
        end
        if (cmd.emit_space)
        begin
            out_byte_next  = SPACE_CHAR;
            last_next      = 1'b1;
            bad_next       = 1'b0;
            out_valid_next = 1'b1;
        end
        if (cmd.emit_dec)
        begin
            out_byte_next  = bad_word_reg ? 8'd0 : sh_reg[7:0];
            last_next      = 1'b1;
            bad_next       = bad_word_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            key_reg       <= KEY_BITS'(1);
            acc_reg       <= '0;
            ov_reg        <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            key_reg       <= key_next;
            acc_reg       <= acc_next;
            ov_reg        <= ov_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg        <= m_next;
        sh_reg       <= sh_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        bad_word_reg <= bad_word_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        bad_reg      <= bad_next;
        if (cmd.digit_store)
        begin
            buf_reg[IDX_W'(n_reg)] <= enc_rem;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign bad_text    = bad_reg;

    assign sts.decode_mode = mode_reg;
    assign sts.in_is_space = (in_byte == SPACE_CHAR);
    assign sts.prod_zero   = (sh_reg == '0);
    assign sts.n_full      = (n_reg == NW'(MAX_DIGITS));
    assign sts.n_zero      = (n_reg == '0);
    assign sts.out_free    = out_free;

endmodule

@@ sv/base62_scaled_text_cipher.sv @@
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_byte
// out       output     out_valid / out_stall out_byte, last_of_run, bad_text
// cfg       input      cfg_write_en         cfg_index, cfg_data
//
// Encode: the byte is scaled (take, then mul), then each digit is divided out by
// the divide-by-62 unit (8 bits a cycle; SH = 56 at the default key width), one
// more check ends the digits, then one character per cycle is emitted while the
// output is not stalled.
// Decode: a text character is taken while the block stays idle; a space runs
// the bit-serial key*67 divider over all SH bits of the shift register.
// Reset is asynchronous; the key resets to 1, the accumulator to zero.
// A stalled output word holds; the next input word is taken while it waits.
module base62_scaled_text_cipher
    import b62stc_pkg::*;
#(
    parameter int KEY_BITS   = 40,
    parameter int MAX_DIGITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  last_of_run,
    output logic                  bad_text
);

    b62stc_cmd_t cmd;
    b62stc_sts_t sts;

    b62stc_ctrl #(
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    b62stc_dp #(
        .KEY_BITS   (KEY_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_byte      (in_byte),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .bad_text     (bad_text),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import b62stc_pkg::*;

    localparam int          MAX_DIGITS   = 10;
    localparam int          SETTLE       = 120;
    localparam longint      RUN_LIMIT_NS = 5_000_000;
    localparam logic [39:0] KEY_MAX      = 40'hFF_FFFF_FFFF;
    localparam logic [63:0] ACC_LIMIT    = 64'h00FF_FFFF_FFFF_FFFF;

    localparam logic                 MODE_ENCODE = 1'b0;
    localparam logic                 MODE_DECODE = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       bad;
    } out_word_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [7:0]            in_byte      = 8'h00;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [7:0]            out_byte;
    logic                  last_of_run;
    logic                  bad_text;

    // predictor copy of the block's registers and state
    logic        mode_copy     = MODE_ENCODE;
    logic [39:0] key_copy      = 40'd1;
    logic [55:0] acc_copy      = '0;
    logic        overflow_copy = 1'b0;

    logic [7:0] pending_bytes [$];
    out_word_t  awaited_words [$];
    int         mismatches = 0;
    int         send_gap   = 0;
    int         stall_left = 0;
    logic       quiet      = 1'b0;

    base62_scaled_text_cipher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .bad_text     (bad_text)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        if (d < 6'd10)
        begin
            return 8'h30 + 8'(d);
        end
        if (d < 6'd36)
        begin
            return 8'h57 + 8'(d);
        end
        return 8'h1D + 8'(d);
    endfunction

    function automatic int char_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - 48;
        end
        if (c >= "a" && c <= "z")
        begin
            return int'(c) - 87;
        end
        if (c >= "A" && c <= "Z")
        begin
            return int'(c) - 29;
        end
        return -1;
    endfunction

    // base-62 text of plain*67*key, most significant digit in text[0]
    function automatic int scaled_text(input logic [7:0] plain, input logic [39:0] key,
                                       output logic [MAX_DIGITS-1:0][7:0] text);
        logic [63:0] prod;
        logic [5:0]  lsd [MAX_DIGITS];
        int          n;
        prod = 64'(plain) * 64'd67 * 64'(key);
        n    = 0;
        text = '0;
        while (prod != 0 && n < MAX_DIGITS)
        begin
            lsd[n] = 6'(prod % 64'd62);
            prod   = prod / 64'd62;
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            text[i] = digit_char(lsd[n - 1 - i]);
        end
        return n;
    endfunction

    task automatic cipher_step(input logic [7:0] c);
        logic [MAX_DIGITS-1:0][7:0] text;
        logic [63:0]                quot;
        int                         n;
        int                         d;
        if (mode_copy == MODE_ENCODE)
        begin
            n = scaled_text(c, key_copy, text);
            for (int i = 0; i < n; i++)
            begin
                awaited_words.push_back(out_word_t'{text[i], 1'b0, 1'b0});
            end
            awaited_words.push_back(out_word_t'{SPACE_CHAR, 1'b1, 1'b0});
        end
        else if (c == SPACE_CHAR)
        begin
            if (overflow_copy || key_copy == 0)
            begin
                awaited_words.push_back(out_word_t'{8'h00, 1'b1, 1'b1});
            end
            else
            begin
                quot = (64'(acc_copy) / 64'(key_copy)) / 64'd67;
                awaited_words.push_back(out_word_t'{quot[7:0], 1'b1, 1'b0});
            end
            acc_copy      = '0;
            overflow_copy = 1'b0;
        end
        else
        begin
            d = char_digit(c);
            if (d < 0)
            begin
                overflow_copy = 1'b1;
            end
            else if (!overflow_copy)
            begin
                if (64'(acc_copy) > (ACC_LIMIT - 64'(d)) / 64'd62)
                begin
                    overflow_copy = 1'b1;
                end
                else
                begin
                    acc_copy = 56'(64'(acc_copy) * 64'd62 + 64'(d));
                end
            end
        end
    endtask

    // input driver: predict on acceptance, then load the next byte after a gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cipher_step(in_byte);
                send_gap = pick_gap();
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= pending_bytes.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: check each accepted word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_check
        out_word_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_words.size() == 0)
                begin
                    $display("%0t: word with nothing expected: out_byte %h last %b bad %b",
                             $time, out_byte, last_of_run, bad_text);
                    mismatches++;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (out_byte !== want.ch)
                    begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.ch, out_byte);
                        mismatches++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $display("%0t: last_of_run expected %b actual %b",
                                 $time, want.last, last_of_run);
                        mismatches++;
                    end
                    if (bad_text !== want.bad)
                    begin
                        $display("%0t: bad_text expected %b actual %b",
                                 $time, want.bad, bad_text);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [39:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_DECODE_MODE)
        begin
            mode_copy = data[0];
        end
        else if (idx == CFG_KEY_VALUE)
        begin
            key_copy = data;
        end
        @(negedge clk);
    endtask

    // hold until every byte is taken and every result is back, then let the block settle
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_bytes.size() != 0 || in_valid || awaited_words.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            pending_bytes.push_back(8'(s[i]));
        end
    endtask

    task automatic push_random_bytes(input int count);
        for (int i = 0; i < count; i++)
        begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic logic [39:0] random_key();
        logic [39:0] k;
        k = {8'($urandom_range(0, 255)), 32'($urandom)};
        return (k == 0) ? 40'd1 : k;
    endfunction

    task automatic queue_words(input int count);
        logic [MAX_DIGITS-1:0][7:0] text;
        int                         n;
        int                         r;
        int                         len;
        for (int w = 0; w < count; w++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                // well-formed word, sometimes with one character corrupted
                n = scaled_text(8'($urandom_range(0, 255)), key_copy, text);
                if (r >= 70 && n > 0)
                begin
                    text[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
                end
                for (int i = 0; i < n; i++)
                begin
                    pending_bytes.push_back(text[i]);
                end
            end
            else if (r < 92)
            begin
                len = $urandom_range(0, 12);
                for (int i = 0; i < len; i++)
                begin
                    pending_bytes.push_back(digit_char(6'($urandom_range(0, 61))));
                end
            end
            else
            begin
                push_random_bytes($urandom_range(1, 4));
            end
            pending_bytes.push_back(SPACE_CHAR);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // encode extremes at the widest key
        write_reg(CFG_DECODE_MODE, 40'(MODE_ENCODE));
        write_reg(CFG_KEY_VALUE, KEY_MAX);
        pending_bytes.push_back(8'h00);
        push_text("\377\001\252");
        wait_drained();

        // a write past the register list must change nothing
        write_reg(CFG_SPARE, random_key());
        write_reg(CFG_KEY_VALUE, 40'd0);
        push_text("\377");
        wait_drained();
        write_reg(CFG_DECODE_MODE, 40'(MODE_DECODE));
        push_text("1 ");
        wait_drained();

        // empty word, wide quotient, bad character, overflow, then a word left open
        write_reg(CFG_KEY_VALUE, 40'd1);
        push_text(" zzz 1! ZZZZZZZZZZ 1");
        wait_drained();
        write_reg(CFG_DECODE_MODE, 40'(MODE_ENCODE));
        push_text("\020");
        wait_drained();
        write_reg(CFG_DECODE_MODE, 40'(MODE_DECODE));
        push_text("a ");
        wait_drained();

        // random encode, paused halfway until all results are back
        write_reg(CFG_DECODE_MODE, 40'(MODE_ENCODE));
        write_reg(CFG_KEY_VALUE, random_key());
        push_random_bytes(8);
        wait_drained();
        push_random_bytes(8);
        wait_drained();

        quiet = 1'b1;
        write_reg(CFG_KEY_VALUE, 40'($urandom_range(1, 255)));
        push_random_bytes(8);
        wait_drained();
        quiet = 1'b0;

        write_reg(CFG_DECODE_MODE, 40'(MODE_DECODE));
        write_reg(CFG_KEY_VALUE, 40'($urandom_range(1, 65535)));
        queue_words(3);
        wait_drained();

        write_reg(CFG_KEY_VALUE, random_key());
        queue_words(3);
        wait_drained();

        write_reg(CFG_DECODE_MODE, 40'(MODE_ENCODE));
        write_reg(CFG_KEY_VALUE, KEY_MAX);
        push_random_bytes(10);
        wait_drained();

        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
